// ----- src/assert_macros.svh -----
// Assertion macros used by the checker.
// The clock is clk and the reset is rst in every user of these macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define SOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define SOA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/soa_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soa_pkg
// Shared widths, codes and the controller/datapath interface types of the
// slab object allocator.
// ---------------------------------------------------------------------------
package soa_pkg;

  localparam int HANDLE_W    = 17;
  localparam int INDEX_W     = 13;
  localparam int CNT_W       = 13;
  localparam int CLS_W       = 4;
  localparam int OFF_W       = 16;
  localparam int STAT_W      = 2;
  localparam int WORD_BITS   = 64;
  localparam int POS_W       = 6;
  localparam int MAX_CLASSES = 12;

  // objects per slab for each class before the frame-size limit
  localparam logic [CNT_W-1:0] CLASS_OBJECTS [MAX_CLASSES] = '{
    13'd5363, 13'd4022, 13'd2681, 13'd1609, 13'd893, 13'd473,
    13'd243,  13'd123,  13'd62,   13'd31,   13'd15,  13'd7
  };

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  // which result the datapath stages
  typedef enum logic [2:0] {
    RES_NONE     = 3'd0,
    RES_TOO_BIG  = 3'd1,
    RES_NO_FRAME = 3'd2,
    RES_BAD_FREE = 3'd3,
    RES_ALLOC_OK = 3'd4,
    RES_FREE_OK  = 3'd5,
    RES_RELEASED = 3'd6
  } res_t;

  typedef struct packed {
    logic latch;
    logic walk_init;
    logic walk_step;
    logic take_frame;
    logic scan_start;
    logic scan_next;
    logic pick;
    logic set_bit;
    logic clr_bit;
    logic unlink_init;
    logic unlink_step;
    logic release_frame;
    res_t res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic size_bad;
    logic cur_null;
    logic cur_room;
    logic steps_done;
    logic pool_full;
    logic word_full;
    logic free_bad;
    logic bit_clear;
    logic last_obj;
    logic wp_null;
    logic wp_hit;
    logic out_free;
  } sts_t;

endpackage

// ----- src/soa_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soa_ctrl
// Request sequencer: decodes, walks slab chains, scans the bitmap, unlinks
// released slabs and hands results to the output register.
// ---------------------------------------------------------------------------
module soa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  soa_pkg::sts_t   sts,
  output soa_pkg::cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_SET    = 7'b0010000,
    S_UNLINK = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.kind) begin
          if (sts.size_bad) begin
            cmd.res    = soa_pkg::RES_TOO_BIG;
            state_next = S_DONE;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK;
          end
        end else if (sts.free_bad || sts.bit_clear) begin
          cmd.res    = soa_pkg::RES_BAD_FREE;
          state_next = S_DONE;
        end else begin
          cmd.clr_bit = 1'b1;
          if (sts.last_obj) begin
            cmd.unlink_init = 1'b1;
            state_next      = S_UNLINK;
          end else begin
            cmd.res    = soa_pkg::RES_FREE_OK;
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (sts.cur_null || sts.steps_done) begin
          if (sts.pool_full) begin
            cmd.res    = soa_pkg::RES_NO_FRAME;
            state_next = S_DONE;
          end else begin
            cmd.take_frame = 1'b1;
            state_next     = S_SET;
          end
        end else if (sts.cur_room) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.word_full) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.pick   = 1'b1;
          state_next = S_SET;
        end
      end
      S_SET: begin
        cmd.set_bit = 1'b1;
        cmd.res     = soa_pkg::RES_ALLOC_OK;
        state_next  = S_DONE;
      end
      S_UNLINK: begin
        if (sts.wp_null || sts.steps_done || sts.wp_hit) begin
          cmd.release_frame = 1'b1;
          cmd.res           = soa_pkg::RES_RELEASED;
          state_next        = S_DONE;
        end else begin
          cmd.unlink_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/soa_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soa_datapath
// Frame tables, class chains, object bitmap memory, result staging and the
// output register.
// ---------------------------------------------------------------------------
module soa_datapath #(
  parameter int NUM_CLASSES = 12,
  parameter int NUM_FRAMES  = 16,
  parameter int MAX_OBJECTS = 8192,
  parameter int FRAME_BYTES = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_kind,
  input  logic [soa_pkg::HANDLE_W-1:0]   in_size,
  input  logic [soa_pkg::HANDLE_W-1:0]   in_handle,
  input  soa_pkg::cmd_t                  cmd,
  output soa_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [39:0]                    out_data
);

  localparam int FB    = $clog2(NUM_FRAMES + 1);
  localparam int FI    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CI    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int WORDS = (MAX_OBJECTS + soa_pkg::WORD_BITS - 1) / soa_pkg::WORD_BITS;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int UW    = $clog2(WORDS + 1);
  localparam int MEM_DEPTH = 1 << (FI + WW);
  localparam logic [FB-1:0] NULL_F = FB'(NUM_FRAMES);

  localparam int CW = soa_pkg::CNT_W;
  localparam int XW = soa_pkg::INDEX_W;
  localparam int PW = soa_pkg::POS_W;
  localparam int DW = soa_pkg::WORD_BITS;

  // objects per slab for each class
  logic [CW-1:0] tot_tab [NUM_CLASSES];
  genvar k;
  for (k = 0; k < NUM_CLASSES; k++) begin : g_tot
    localparam int FIT = FRAME_BYTES / ((4 << k) + 8);
    localparam int N1  = (int'(soa_pkg::CLASS_OBJECTS[k]) < MAX_OBJECTS) ?
                         int'(soa_pkg::CLASS_OBJECTS[k]) : MAX_OBJECTS;
    localparam int N2  = (N1 < FIT) ? N1 : FIT;
    localparam int N3  = (N2 < 1) ? 1 : N2;
    assign tot_tab[k] = CW'(N3);
  end

  // frame tables and class chains
  logic          in_use [NUM_FRAMES];
  logic [3:0]    fclass [NUM_FRAMES];
  logic [CW-1:0] fcount [NUM_FRAMES];
  logic [FB-1:0] fnext  [NUM_FRAMES];
  logic [UW-1:0] used   [NUM_FRAMES];
  logic [FB-1:0] head   [NUM_CLASSES];
  logic [FB-1:0] tail   [NUM_CLASSES];

  // request registers
  logic          kind_q, size_bad_q, frame_bad_q;
  logic [3:0]    cls;
  logic [FB-1:0] cur, cur_n, wp, prev, steps;
  logic [WW-1:0] word_idx, word_n;
  logic [XW-1:0] idx;

  // bitmap memory
  logic [DW-1:0] mem [MEM_DEPTH];
  logic [DW-1:0] mem_q, rd, bitmask, wdata;
  logic          zero_q, zero_n, we;

  // result staging
  logic [1:0]    res_st;
  logic [16:0]   res_handle;
  logic [15:0]   res_off;
  logic [3:0]    res_cls;
  logic          res_rel;

  logic [FI-1:0] cur_i, wp_i, prev_i, tail_i, free_i;
  logic [CI-1:0] cls_i;
  logic [CW-1:0] total;
  logic [3:0]    size_cls;
  logic          size_big, hf_ok, pool_full;
  logic [4:0]    hf5;
  logic [PW-1:0] pos;
  logic [UW-1:0] wn1;
  logic [31:0]   off32;

  assign cur_i  = cur[FI-1:0];
  assign wp_i   = wp[FI-1:0];
  assign prev_i = prev[FI-1:0];
  assign cls_i  = cls[CI-1:0];
  assign tail_i = tail[cls_i][FI-1:0];
  assign total  = (32'(cls) < NUM_CLASSES) ? tot_tab[cls_i] : CW'(1);
  assign hf5    = {1'b0, in_handle[soa_pkg::HANDLE_W-1:XW]};
  assign hf_ok  = 32'(hf5) < NUM_FRAMES;

  // size to class
  always_comb begin
    size_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (32'(in_size) <= (32'd4 << c)) size_cls = 4'(c);
    end
    size_big = 32'(in_size) > (32'd4 << (NUM_CLASSES - 1));
  end

  // lowest unused frame
  always_comb begin
    free_i    = '0;
    pool_full = 1'b1;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (!in_use[f]) begin
        free_i    = FI'(f);
        pool_full = 1'b0;
      end
    end
  end

  // bitmap word and first clear bit
  assign rd = zero_q ? '0 : mem_q;
  always_comb begin
    pos = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      if (!rd[b]) pos = PW'(b);
    end
  end
  assign bitmask = DW'(1) << idx[PW-1:0];
  assign we      = cmd.set_bit || cmd.clr_bit;
  assign wdata   = cmd.set_bit ? (rd | bitmask) : (rd & ~bitmask);
  assign wn1     = UW'(32'(word_idx) + 1);

  // next frame and word pointers feed the memory read address
  always_comb begin
    cur_n  = cur;
    word_n = word_idx;
    if (cmd.latch) begin
      cur_n  = FB'(hf5);
      word_n = WW'(in_handle[XW-1:PW]);
    end
    if (cmd.walk_init)  cur_n = head[cls_i];
    if (cmd.walk_step)  cur_n = fnext[cur_i];
    if (cmd.take_frame) begin
      cur_n  = FB'(free_i);
      word_n = '0;
    end
    if (cmd.scan_start) word_n = '0;
    if (cmd.scan_next)  word_n = word_idx + WW'(1);
    zero_n = cmd.take_frame ||
             (32'(word_n) >= 32'(used[cur_n[FI-1:0]]));
  end

  always_ff @(posedge clk) begin
    if (we) mem[{cur_i, word_idx}] <= wdata;
    mem_q <= mem[{cur_n[FI-1:0], word_n}];
  end

  // request registers
  always_ff @(posedge clk) begin
    cur      <= cur_n;
    word_idx <= word_n;
    zero_q   <= zero_n;
    if (cmd.latch) begin
      kind_q      <= in_kind;
      size_bad_q  <= size_big;
      frame_bad_q <= !hf_ok;
      idx         <= in_handle[XW-1:0];
      if (in_kind) cls <= hf_ok ? fclass[FI'(hf5)] : 4'd0;
      else         cls <= size_cls;
    end
    if (cmd.walk_init || cmd.unlink_init) steps <= '0;
    if (cmd.walk_step || cmd.unlink_step) steps <= steps + FB'(1);
    if (cmd.unlink_init) begin
      wp   <= head[cls_i];
      prev <= NULL_F;
    end
    if (cmd.unlink_step) begin
      prev <= wp;
      wp   <= fnext[wp_i];
    end
    if (cmd.take_frame) idx <= '0;
    if (cmd.pick)       idx <= XW'({word_idx, pos});
  end

  // frame tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < NUM_FRAMES; f++) begin
        in_use[f] <= 1'b0;
        fclass[f] <= '0;
        fcount[f] <= '0;
        fnext[f]  <= NULL_F;
        used[f]   <= '0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= NULL_F;
        tail[c] <= NULL_F;
      end
    end else begin
      if (cmd.take_frame) begin
        in_use[free_i] <= 1'b1;
        fclass[free_i] <= cls;
        fcount[free_i] <= total;
        fnext[free_i]  <= NULL_F;
        used[free_i]   <= '0;
        if (tail[cls_i] != NULL_F) fnext[tail_i] <= FB'(free_i);
        else                       head[cls_i]   <= FB'(free_i);
        tail[cls_i] <= FB'(free_i);
      end
      if (cmd.set_bit) begin
        fcount[cur_i] <= fcount[cur_i] - CW'(1);
        if (wn1 > used[cur_i]) used[cur_i] <= wn1;
      end
      if (cmd.clr_bit) fcount[cur_i] <= fcount[cur_i] + CW'(1);
      if (cmd.release_frame) begin
        if (wp == cur) begin
          if (prev != NULL_F) fnext[prev_i] <= fnext[cur_i];
          else                head[cls_i]   <= fnext[cur_i];
          if (tail[cls_i] == cur) tail[cls_i] <= prev;
        end
        in_use[cur_i] <= 1'b0;
        fclass[cur_i] <= '0;
        fcount[cur_i] <= '0;
        fnext[cur_i]  <= NULL_F;
      end
    end
  end

  // result staging
  assign off32 = 32'd8 + (32'(idx) << (32'(cls) + 2)) + (32'(idx) << 3);
  always_ff @(posedge clk) begin
    unique case (cmd.res)
      soa_pkg::RES_NONE: ;
      soa_pkg::RES_TOO_BIG, soa_pkg::RES_BAD_FREE: begin
        res_st     <= (cmd.res == soa_pkg::RES_TOO_BIG) ? soa_pkg::ST_TOO_BIG
                                                        : soa_pkg::ST_BAD_FREE;
        res_handle <= '0;
        res_off    <= '0;
        res_cls    <= '0;
        res_rel    <= 1'b0;
      end
      soa_pkg::RES_NO_FRAME, soa_pkg::RES_FREE_OK, soa_pkg::RES_RELEASED: begin
        res_st     <= (cmd.res == soa_pkg::RES_NO_FRAME) ? soa_pkg::ST_NO_FRAME
                                                         : soa_pkg::ST_OK;
        res_handle <= '0;
        res_off    <= '0;
        res_cls    <= cls;
        res_rel    <= (cmd.res == soa_pkg::RES_RELEASED);
      end
      soa_pkg::RES_ALLOC_OK: begin
        res_st     <= soa_pkg::ST_OK;
        res_handle <= 17'((32'(cur) << XW) | 32'(idx));
        res_off    <= off32[15:0];
        res_cls    <= cls;
        res_rel    <= 1'b0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {res_rel, res_cls, res_off, res_handle, res_st};
  end

  // status to the controller
  assign sts.kind       = kind_q;
  assign sts.size_bad   = size_bad_q;
  assign sts.cur_null   = 32'(cur) >= NUM_FRAMES;
  assign sts.cur_room   = fcount[cur_i] != '0;
  assign sts.steps_done = 32'(steps) >= NUM_FRAMES;
  assign sts.pool_full  = pool_full;
  assign sts.word_full  = &rd;
  assign sts.free_bad   = frame_bad_q || !in_use[cur_i] ||
                          (32'(cls) >= NUM_CLASSES) || (idx >= total);
  assign sts.bit_clear  = !rd[idx[PW-1:0]];
  assign sts.last_obj   = ({1'b0, fcount[cur_i]} + (CW + 1)'(1)) == {1'b0, total};
  assign sts.wp_null    = 32'(wp) >= NUM_FRAMES;
  assign sts.wp_hit     = wp == cur;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ----- src/slab_object_allocator_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slab_object_allocator_core
// Slab allocator over a fixed frame pool with power-of-two object classes.
// ---------------------------------------------------------------------------
// Channel  Dir  Contents
// s_*      in   tuser: kind; tdata: request_size, object_handle
// m_*      out  tdata: status, result_handle, object_offset, size_class,
//               slab_released
//
// Allocate: walks the class chain, then scans bitmap words (64 bits each)
// for a clear bit through the one bitmap memory port. Free: clears the
// object's bit, then unlinks the slab from its chain when it is released.
// One request at a time; a new one is taken while the last result waits in
// the output register. Reset clears all tables; bitmap rows need no clearing
// since each frame keeps a count of the bitmap words it has used.
module slab_object_allocator_core #(
  parameter int NUM_CLASSES = 12,
  parameter int NUM_FRAMES  = 16,
  parameter int MAX_OBJECTS = 8192,
  parameter int FRAME_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_size[16:0], object_handle[33:17]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], result_handle[18:2],
                                 // object_offset[34:19], size_class[38:35],
                                 // slab_released[39]
);

  soa_pkg::cmd_t cmd;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  soa_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_FRAMES  (NUM_FRAMES),
    .MAX_OBJECTS (MAX_OBJECTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_kind   (s_tuser),
    .in_size   (s_tdata[16:0]),
    .in_handle (s_tdata[33:17]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ----- src/soa_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soa_checker
// Port-level checks of the slab allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module soa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // stalled result beat holds
  `SOA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed under stall")

  // only one request in flight
  `SOA_ASSERT(a_one_req, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

  // error results carry no handle, offset, class or release
  `SOA_ASSERT(a_err_zero, m_tvalid && (m_tdata[1:0] == soa_pkg::ST_TOO_BIG || m_tdata[1:0] == soa_pkg::ST_BAD_FREE) |-> m_tdata[39:2] == 38'd0, "error result with payload")

  // no result straight out of reset
  `SOA_ASSERT_ALWAYS(a_rst_quiet, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (.*);
